// ----- src/tbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tbd_pkg;

   localparam int TIME_W     = 63;
   localparam int SAMPLE_W   = 32;
   localparam int AGG_W      = 48;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int INTERVAL_W = 22;
   localparam int MODE_W     = 4;
   localparam int WIDTH_MS_W = 32;
   localparam int END_W      = 64;
   localparam int FRAC_W     = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS  = AGG_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AGG_MODE = CSR_IDX_W'(1);

   localparam logic [WIDTH_MS_W-1:0] WIDTH_MS_RESET = WIDTH_MS_W'(300000);

   localparam logic [MODE_W-1:0] MODE_AVG   = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_SUM   = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_MIN   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_MAX   = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_COUNT = MODE_W'(4);
   localparam logic [MODE_W-1:0] MODE_RATE  = MODE_W'(5);
   localparam logic [MODE_W-1:0] MODE_IRATE = MODE_W'(6);
   localparam logic [MODE_W-1:0] MODE_DELTA = MODE_W'(7);

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ----- src/tbd_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tbd_req_if import tbd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [TIME_W-1:0]          sample_time;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic                       series_last;

   modport source (output valid, sample_time, sample_value, series_last, input ready);
   modport sink   (input valid, sample_time, sample_value, series_last, output ready);
endinterface

`default_nettype wire

// ----- src/tbd_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tbd_rsp_if import tbd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TIME_W-1:0]       bucket_time;
   logic signed [AGG_W-1:0] bucket_value;
   logic                    final_bucket;

   modport source (output valid, bucket_time, bucket_value, final_bucket, input ready);
   modport sink   (input valid, bucket_time, bucket_value, final_bucket, output ready);
endinterface

`default_nettype wire

// ----- src/tbd_csr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tbd_csr_if import tbd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/time_bucket_downsampler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Time bucket downsampler: takes one series' samples in time order and emits one
// aggregate per bucket, whose width in seconds comes from the interval register, plus a
// final flush on the last sample of the series. The front end takes one sample per
// cycle while the queue has room; it holds off new samples while a final flush is
// pending and while the bucket end is recomputed after an interval write. Closed
// buckets go through a two-entry queue to the back end, which loads a result straight
// into the result register for every mode except average; an average result runs a
// bit-serial divider, which takes a new bucket only once it has handed off the last,
// so back-to-back bucket closes in average mode wait on the divider. The result
// register lets the back end start dividing the next average bucket while a finished
// result waits on rsp_ch.
module time_bucket_downsampler_core import tbd_pkg::*; #(
   parameter int MAX_BUCKET_SAMPLES = 128
) (
   input  wire logic clock,
   input  wire logic reset,
   tbd_req_if.sink   req_ch,
   tbd_rsp_if.source rsp_ch,
   tbd_csr_if.sink   csr_ch
);

   localparam int CNT_W   = $clog2(MAX_BUCKET_SAMPLES + 1);
   localparam int ENTRY_W = TIME_W + AGG_W + CNT_W + 2;

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;
   logic [TIME_W-1:0]  ent_time;
   logic [AGG_W-1:0]   ent_value;
   logic [CNT_W-1:0]   ent_count;
   logic               ent_avg;
   logic               ent_final;
   logic [ENTRY_W-1:0] push_data;
   logic [ENTRY_W-1:0] pop_data;
   logic [TIME_W-1:0]  q_time;
   logic [AGG_W-1:0]   q_value;
   logic [CNT_W-1:0]   q_count;
   logic               q_avg;
   logic               q_final;

   tbd_front #(
      .MAX_BUCKET_SAMPLES (MAX_BUCKET_SAMPLES),
      .CNT_W              (CNT_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_ch    (csr_ch),
      .q_full    (q_full),
      .push      (push),
      .ent_time  (ent_time),
      .ent_value (ent_value),
      .ent_count (ent_count),
      .ent_avg   (ent_avg),
      .ent_final (ent_final)
   );

   assign push_data = {ent_time, ent_value, ent_count, ent_avg, ent_final};
   assign {q_time, q_value, q_count, q_avg, q_final} = pop_data;

   tbd_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   tbd_back #(
      .CNT_W (CNT_W)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_time  (q_time),
      .q_value (q_value),
      .q_count (q_count),
      .q_avg   (q_avg),
      .q_final (q_final),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- src/tbd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbd_queue import tbd_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == CNT_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- src/tbd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbd_front import tbd_pkg::*; #(
   parameter int MAX_BUCKET_SAMPLES = 128,
   parameter int CNT_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tbd_req_if.sink                req_ch,
   tbd_csr_if.sink                csr_ch,
   input  wire logic              q_full,
   output logic                   push,
   output logic [TIME_W-1:0]      ent_time,
   output logic [AGG_W-1:0]       ent_value,
   output logic [CNT_W-1:0]       ent_count,
   output logic                   ent_avg,
   output logic                   ent_final
);

   logic [WIDTH_MS_W-1:0]      width_ms_ff;
   logic [MODE_W-1:0]          agg_mode_ff;
   logic                       open_ff, open_in;
   logic                       pend_ff, pend_in;
   logic                       dirty_ff, dirty_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [TIME_W-1:0]          start_ff, start_in;
   logic [END_W-1:0]           end_ff, end_in;
   logic signed [AGG_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic signed [SAMPLE_W-1:0] first_ff, first_in;
   logic signed [SAMPLE_W-1:0] latest_ff, latest_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;

   logic                        accept;
   logic                        csr_wr;
   logic                        closing;
   logic [WIDTH_MS_W-1:0]       csr_width_ms;
   logic signed [SAMPLE_W-1:0]  v;
   logic [AGG_W:0]              sum_ext;
   logic signed [SAMPLE_W:0]    diff_first;
   logic signed [SAMPLE_W:0]    diff_prev;
   logic                        few;

   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;
   assign req_ch.ready = !pend_ff && !dirty_ff && !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign v            = req_ch.sample_value;
   assign closing      = open_ff && ({1'b0, req_ch.sample_time} >= end_ff);

   // ms = s * 1000 = s * (1024 - 32 + 8)
   assign csr_width_ms = {csr_ch.data[INTERVAL_W-1:0], 10'b0}
                       - WIDTH_MS_W'({csr_ch.data[INTERVAL_W-1:0], 5'b0})
                       + WIDTH_MS_W'({csr_ch.data[INTERVAL_W-1:0], 3'b0});

   assign sum_ext = {sum_ff[AGG_W-1], sum_ff}
                  + {{(AGG_W + 1 - SAMPLE_W){v[SAMPLE_W-1]}}, v};

   // aggregate of the bucket held in the registers
   assign diff_first = {latest_ff[SAMPLE_W-1], latest_ff} - {first_ff[SAMPLE_W-1], first_ff};
   assign diff_prev  = {latest_ff[SAMPLE_W-1], latest_ff} - {prev_ff[SAMPLE_W-1], prev_ff};
   assign few        = (count_ff < CNT_W'(2));

   always_comb begin
      ent_avg   = 1'b0;
      ent_value = sum_ff;
      unique case (agg_mode_ff)
         MODE_AVG: begin
            ent_avg = 1'b1;
         end
         MODE_SUM: begin
            ent_value = sum_ff;
         end
         MODE_MIN: begin
            ent_value = {{(AGG_W - SAMPLE_W){min_ff[SAMPLE_W-1]}}, min_ff};
         end
         MODE_MAX: begin
            ent_value = {{(AGG_W - SAMPLE_W){max_ff[SAMPLE_W-1]}}, max_ff};
         end
         MODE_COUNT: begin
            ent_value = AGG_W'(count_ff) << FRAC_W;
         end
         MODE_RATE: begin
            ent_value = few ? '0
                      : {{(AGG_W - SAMPLE_W - 1){diff_first[SAMPLE_W]}}, diff_first};
         end
         MODE_IRATE, MODE_DELTA: begin
            ent_value = few ? '0
                      : {{(AGG_W - SAMPLE_W - 1){diff_prev[SAMPLE_W]}}, diff_prev};
         end
         default: begin
            ent_value = {{(AGG_W - SAMPLE_W){first_ff[SAMPLE_W-1]}}, first_ff};
         end
      endcase
   end

   assign push      = (accept && closing) || (pend_ff && !q_full);
   assign ent_final = pend_ff;
   assign ent_time  = start_ff;
   assign ent_count = count_ff;

   always_comb begin
      open_in   = open_ff;
      pend_in   = pend_ff;
      dirty_in  = dirty_ff;
      count_in  = count_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      sum_in    = sum_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      first_in  = first_ff;
      latest_in = latest_ff;
      prev_in   = prev_ff;

      if (csr_wr && csr_ch.index == CSR_INTERVAL) begin
         dirty_in = 1'b1;
      end else if (dirty_ff) begin
         dirty_in = 1'b0;
         end_in   = {1'b0, start_ff} + END_W'(width_ms_ff);
      end

      if (accept) begin
         if (!open_ff || closing) begin
            open_in   = 1'b1;
            start_in  = req_ch.sample_time;
            end_in    = {1'b0, req_ch.sample_time} + END_W'(width_ms_ff);
            count_in  = CNT_W'(1);
            sum_in    = {{(AGG_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
            min_in    = v;
            max_in    = v;
            first_in  = v;
            latest_in = v;
            prev_in   = v;
         end else begin
            priority if (sum_ext[AGG_W] != sum_ext[AGG_W-1]) begin
               sum_in = sum_ext[AGG_W] ? {1'b1, {(AGG_W - 1){1'b0}}}
                                       : {1'b0, {(AGG_W - 1){1'b1}}};
            end else begin
               sum_in = sum_ext[AGG_W-1:0];
            end
            if (v < min_ff) begin
               min_in = v;
            end
            if (v > max_ff) begin
               max_in = v;
            end
            prev_in   = latest_ff;
            latest_in = v;
            if (count_ff < CNT_W'(MAX_BUCKET_SAMPLES)) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         if (req_ch.series_last) begin
            pend_in = 1'b1;
         end
      end

      if (pend_ff && !q_full) begin
         pend_in  = 1'b0;
         open_in  = 1'b0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ms_ff <= WIDTH_MS_RESET;
         agg_mode_ff <= MODE_AVG;
         open_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         dirty_ff    <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (csr_wr && csr_ch.index == CSR_INTERVAL) begin
            width_ms_ff <= csr_width_ms;
         end
         if (csr_wr && csr_ch.index == CSR_AGG_MODE) begin
            agg_mode_ff <= csr_ch.data[MODE_W-1:0];
         end
         open_ff  <= open_in;
         pend_ff  <= pend_in;
         dirty_ff <= dirty_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      end_ff    <= end_in;
      sum_ff    <= sum_in;
      min_ff    <= min_in;
      max_ff    <= max_in;
      first_ff  <= first_in;
      latest_ff <= latest_in;
      prev_ff   <= prev_in;
   end

   assert property (@(posedge clock) disable iff (reset) pend_ff |-> !req_ch.ready)
      else $error("sample taken while final flush pending");
   assert property (@(posedge clock) disable iff (reset) open_ff |-> (count_ff != '0))
      else $error("open bucket with zero count");
   assert property (@(posedge clock) disable iff (reset)
                    (accept && req_ch.series_last) |=> pend_ff)
      else $error("series end did not schedule flush");

endmodule

`default_nettype wire

// ----- src/tbd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tbd_back import tbd_pkg::*; #(
   parameter int CNT_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire logic [TIME_W-1:0] q_time,
   input  wire logic [AGG_W-1:0] q_value,
   input  wire logic [CNT_W-1:0] q_count,
   input  wire logic             q_avg,
   input  wire logic             q_final,
   output logic                  pop,
   tbd_rsp_if.source             rsp_ch
);

   back_state_type state_ff, state_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]   rsp_time_ff;
   logic [AGG_W-1:0]    rsp_value_ff;
   logic                rsp_final_ff;

   logic [TIME_W-1:0]   hold_time_ff;
   logic                hold_final_ff;
   logic                neg_ff;
   logic [CNT_W-1:0]    divisor_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [AGG_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   step_ff;

   logic                out_free;
   logic                load_direct;
   logic                load_div;
   logic                div_start;
   logic [CNT_W:0]      rem_sh;
   logic [CNT_W:0]      rem_sub;
   logic                ge;
   logic [AGG_W-1:0]    quotient;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && q_avg) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      load_direct = 1'b0;
      load_div    = 1'b0;
      div_start   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            div_start   = !q_empty && q_avg;
            load_direct = !q_empty && !q_avg && out_free;
            pop         = div_start || load_direct;
         end
         BK_DONE: begin
            load_div = out_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign rem_sh   = {rem_ff, quo_ff[AGG_W-1]};
   assign rem_sub  = rem_sh - {1'b0, divisor_ff};
   assign ge       = (rem_sh >= {1'b0, divisor_ff});
   assign quotient = neg_ff ? (AGG_W'(0) - quo_ff) : quo_ff;

   assign rsp_valid_in = (load_direct || load_div) ? 1'b1
                       : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         hold_time_ff  <= q_time;
         hold_final_ff <= q_final;
         neg_ff        <= q_value[AGG_W-1];
         quo_ff        <= q_value[AGG_W-1] ? (AGG_W'(0) - q_value) : q_value;
         divisor_ff    <= q_count;
         rem_ff        <= '0;
         step_ff       <= '0;
      end else if (state_ff == BK_DIV) begin
         quo_ff  <= {quo_ff[AGG_W-2:0], ge};
         rem_ff  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         step_ff <= step_ff + STEP_W'(1);
      end
      if (load_direct) begin
         rsp_time_ff  <= q_time;
         rsp_value_ff <= q_value;
         rsp_final_ff <= q_final;
      end else if (load_div) begin
         rsp_time_ff  <= hold_time_ff;
         rsp_value_ff <= quotient;
         rsp_final_ff <= hold_final_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.bucket_time  = rsp_time_ff;
   assign rsp_ch.bucket_value = rsp_value_ff;
   assign rsp_ch.final_bucket = rsp_final_ff;

   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == BK_DIV) |-> (divisor_ff != '0))
      else $error("average with zero count");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import tbd_pkg::*;

   localparam int BUCKET_CAP = 128;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int COUNT_SAT_SAMPLES = 150;
   localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint SUM_HI = 64'sd140737488355327;
   localparam longint SUM_LO = -64'sd140737488355328;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_IDX = {CSR_IDX_W{1'b1}};
   localparam logic [MODE_W-1:0] MODE_FIRST = MODE_W'(8);
   localparam logic [INTERVAL_W-1:0] INTERVAL_DEFAULT = INTERVAL_W'(300);
   localparam logic [INTERVAL_W-1:0] INTERVAL_MONTH = INTERVAL_W'(2592000);
   localparam logic [INTERVAL_W-1:0] INTERVAL_TOP = {INTERVAL_W{1'b1}};

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [TIME_W-1:0]          t;
      logic signed [SAMPLE_W-1:0] v;
      logic                       last;
   } sample_item_type;

   typedef struct {
      logic [TIME_W-1:0]       t;
      logic signed [AGG_W-1:0] v;
      logic                    fin;
   } bucket_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tbd_req_if req_ch();
   tbd_rsp_if rsp_ch();
   tbd_csr_if csr_ch();

   time_bucket_downsampler_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   sample_item_type pending_samples[$];
   bucket_item_type expected_buckets[$];
   sample_item_type offered;
   int samples_queued = 0;
   int samples_accepted = 0;
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   bit hold_armed = 1'b0;
   bit hold_taken = 1'b0;
   int cycles = 0;

   logic [INTERVAL_W-1:0]      cfg_interval = INTERVAL_DEFAULT;
   logic [MODE_W-1:0]          cfg_mode = MODE_AVG;
   logic                       pr_open = 1'b0;
   logic [TIME_W-1:0]          pr_start = '0;
   int                         pr_count = 0;
   longint                     pr_sum = 0;
   logic signed [SAMPLE_W-1:0] pr_lo = '0;
   logic signed [SAMPLE_W-1:0] pr_hi = '0;
   logic signed [SAMPLE_W-1:0] pr_first = '0;
   logic signed [SAMPLE_W-1:0] pr_last = '0;
   logic signed [SAMPLE_W-1:0] pr_prev = '0;

   function automatic logic signed [AGG_W-1:0] bucket_aggregate();
      longint n;
      longint a;
      n = pr_count;
      case (cfg_mode)
         MODE_AVG:   a = (n > 0) ? pr_sum / n : 0;
         MODE_SUM:   a = pr_sum;
         MODE_MIN:   a = longint'(pr_lo);
         MODE_MAX:   a = longint'(pr_hi);
         MODE_COUNT: a = n * 65536;
         MODE_RATE:  a = (n < 2) ? 0 : longint'(pr_last) - longint'(pr_first);
         MODE_IRATE, MODE_DELTA: a = (n < 2) ? 0 : longint'(pr_last) - longint'(pr_prev);
         default:    a = longint'(pr_first);
      endcase
      return a[AGG_W-1:0];
   endfunction

   task automatic emit_bucket(input logic fin);
      bucket_item_type b;
      b.t = pr_start;
      b.v = bucket_aggregate();
      b.fin = fin;
      expected_buckets.push_back(b);
   endtask

   task automatic open_bucket(input sample_item_type s);
      pr_open = 1'b1;
      pr_start = s.t;
      pr_count = 1;
      pr_sum = longint'(s.v);
      pr_lo = s.v;
      pr_hi = s.v;
      pr_first = s.v;
      pr_last = s.v;
      pr_prev = s.v;
   endtask

   task automatic fold_sample(input sample_item_type s);
      logic [63:0] width_ms;
      longint sum_next;
      width_ms = 64'(cfg_interval) * 64'd1000;
      if (!pr_open) begin
         open_bucket(s);
      end else if (s.t >= pr_start && 64'(s.t) - 64'(pr_start) >= width_ms) begin
         emit_bucket(1'b0);
         open_bucket(s);
      end else begin
         sum_next = pr_sum + longint'(s.v);
         if (sum_next > SUM_HI) sum_next = SUM_HI;
         if (sum_next < SUM_LO) sum_next = SUM_LO;
         pr_sum = sum_next;
         if (s.v < pr_lo) pr_lo = s.v;
         if (s.v > pr_hi) pr_hi = s.v;
         pr_prev = pr_last;
         pr_last = s.v;
         if (pr_count < BUCKET_CAP) pr_count++;
      end
      if (s.last) begin
         emit_bucket(1'b1);
         pr_open = 1'b0;
         pr_count = 0;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            fold_sample(offered);
            samples_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = pending_samples.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.sample_time <= offered.t;
               req_ch.sample_value <= offered.v;
               req_ch.series_last <= offered.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_taken <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_left <= HOLD_CYCLES;
         hold_taken <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      bucket_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_buckets.size() == 0) begin
               $error("unexpected bucket: bucket_time %0d bucket_value %0d final_bucket %0b",
                      rsp_ch.bucket_time, rsp_ch.bucket_value, rsp_ch.final_bucket);
               error_count++;
            end else begin
               want = expected_buckets.pop_front();
               if (rsp_ch.bucket_time !== want.t) begin
                  $error("bucket_time: expected %0d, actual %0d", want.t, rsp_ch.bucket_time);
                  error_count++;
               end
               if (rsp_ch.bucket_value !== want.v) begin
                  $error("bucket_value: expected %0d, actual %0d", want.v,
                         rsp_ch.bucket_value);
                  error_count++;
               end
               if (rsp_ch.final_bucket !== want.fin) begin
                  $error("final_bucket: expected %0b, actual %0b", want.fin,
                         rsp_ch.final_bucket);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic push_sample(input logic [63:0] t, input logic [31:0] v, input logic last);
      sample_item_type s;
      s.t = t[TIME_W-1:0];
      s.v = v;
      s.last = last;
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_INTERVAL) cfg_interval = data[INTERVAL_W-1:0];
      else if (idx == CSR_AGG_MODE) cfg_mode = data[MODE_W-1:0];
   endtask

   task automatic wait_quiet();
      while (samples_accepted != samples_queued || expected_buckets.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [INTERVAL_W-1:0] interval, input logic [MODE_W-1:0] mode,
                            input idle_mode_type idle);
      wait_quiet();
      write_reg(CSR_INTERVAL, {(CSR_DATA_W - INTERVAL_W)'($urandom), interval});
      write_reg(CSR_AGG_MODE, {(CSR_DATA_W - MODE_W)'($urandom), mode});
      write_reg(CSR_IDX_W'($urandom_range(CSR_AGG_MODE + 1, CSR_LAST_IDX)), $urandom);
      send_idle_pct = (idle == IDLE_SEND) ? 49 : (idle == IDLE_BOTH) ? 25 : 0;
      recv_stall_pct = (idle == IDLE_RECV) ? 49 : (idle == IDLE_BOTH) ? 25 : 0;
   endtask

   task automatic queue_series(input logic [63:0] width_ms, output int len);
      logic [63:0] t;
      logic [63:0] step;
      logic [31:0] v;
      logic [63:0] back;
      bit dense;
      bit ended;
      dense = ($urandom_range(39) == 0);
      len = dense ? $urandom_range(130, 160) : $urandom_range(1, 12);
      ended = ($urandom_range(99) >= 15);
      case ($urandom_range(3))
         0: t = 64'd0;
         1: t = {$urandom, $urandom} & TIME_MAX;
         2: t = TIME_MAX - 64'($urandom_range(0, 100000));
         default: t = 64'($urandom);
      endcase
      for (int k = 0; k < len; k++) begin
         if (k != 0) begin
            step = 64'd0;
            if (dense) begin
               step = 64'($urandom_range(1));
            end else begin
               case ($urandom_range(9))
                  0: step = 64'd0;
                  1: step = 64'd1;
                  2: step = (width_ms == 0) ? 64'd0 : width_ms - 1;
                  3: step = width_ms;
                  4: step = width_ms + 1;
                  5, 6: step = (width_ms == 0) ? 64'd0 : {$urandom, $urandom} % width_ms;
                  7: step = {$urandom, $urandom} >> $urandom_range(63);
                  8: begin
                     back = 64'($urandom_range(1, 5000));
                     t = (t > back) ? t - back : 64'd0;
                  end
                  default: step = width_ms * 2;
               endcase
            end
            t = (step > TIME_MAX - t) ? TIME_MAX : t + step;
         end
         case ($urandom_range(7))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom;
         endcase
         push_sample(t, v, ended && (k == len - 1));
      end
   endtask

   task automatic run_phase(input logic [INTERVAL_W-1:0] interval,
                            input logic [MODE_W-1:0] mode, input idle_mode_type idle,
                            input int items, input bit hold);
      int queued;
      int len;
      queued = 0;
      configure(interval, mode, idle);
      if (hold) hold_armed = 1'b1;
      while (queued < items) begin
         queue_series(64'(interval) * 64'd1000, len);
         queued += len;
      end
   endtask

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [63:0] base;
      req_ch.valid = 1'b0;
      req_ch.sample_time = '0;
      req_ch.sample_value = '0;
      req_ch.series_last = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: avg over 300 s buckets
      push_sample(64'd0, 32'h7FFF_FFFF, 1'b1);
      push_sample(64'd100, 32'h8000_0000, 1'b0);
      push_sample(64'd100 + 64'd299999, 32'd5, 1'b0);
      push_sample(64'd100 + 64'd300000, 32'd7, 1'b0);
      push_sample(64'd50, 32'hFFFF_FFFF, 1'b0);
      push_sample(TIME_MAX, 32'd3, 1'b1);

      for (int m = 0; m <= MODE_FIRST; m++) begin
         configure(INTERVAL_DEFAULT, MODE_W'(m), IDLE_NONE);
         base = 64'(m) * 64'd1000;
         push_sample(base, 32'h8000_0000, 1'b0);
         if (m == MODE_RATE || m == MODE_IRATE || m == MODE_DELTA) begin
            push_sample(base + 1, 32'h7FFF_FFFF, 1'b0);
            push_sample(base + 2, 32'd12345, 1'b1);
         end else begin
            push_sample(base + 1, 32'h7FFF_FFFF, 1'b1);
         end
      end

      run_phase('0, MODE_AVG, IDLE_NONE, 60, 1'b1);
      run_phase(INTERVAL_DEFAULT, MODE_DELTA, IDLE_SEND, 60, 1'b0);
      run_phase(INTERVAL_W'(1), MODE_MIN, IDLE_RECV, 60, 1'b0);
      run_phase(INTERVAL_MONTH, MODE_MAX, IDLE_BOTH, 60, 1'b0);
      run_phase(INTERVAL_TOP, MODE_COUNT, IDLE_NONE, 60, 1'b0);
      run_phase(INTERVAL_W'($urandom), MODE_RATE, IDLE_SEND, 60, 1'b0);
      run_phase(INTERVAL_W'(60), MODE_IRATE, IDLE_RECV, 60, 1'b0);
      run_phase(INTERVAL_W'($urandom_range(1, 10)), MODE_W'($urandom_range(MODE_FIRST, 15)),
                IDLE_BOTH, 60, 1'b0);
      run_phase(INTERVAL_W'($urandom_range(0, 5)), MODE_SUM, IDLE_BOTH, 40, 1'b0);

      // saturate the count
      configure(INTERVAL_TOP, MODE_COUNT, IDLE_NONE);
      for (int k = 0; k < COUNT_SAT_SAMPLES; k++)
         push_sample(64'd7, $urandom, k == COUNT_SAT_SAMPLES - 1);

      wait_quiet();
      if (error_count == 0 && expected_buckets.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- time_bucket_downsampler_core.f -----
src/tbd_pkg.sv
src/tbd_req_if.sv
src/tbd_rsp_if.sv
src/tbd_csr_if.sv
src/tbd_queue.sv
src/tbd_front.sv
src/tbd_back.sv
src/time_bucket_downsampler_core.sv
tb/testbench.sv
